// File: design/uce_pkg.sv
// Shared types, constants and codes for the UART command output expander.
// No dependencies; every other file in the design imports this package.
package uce_pkg;

    // Default number of output table entries
    localparam int NUM_OUTPUTS_DEF = 21;

    // Entries shown in the shift frame, and the frame width
    localparam int FRAME_ENTRIES = 21;
    localparam int FRAME_W       = 24;

    // Depth of the command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Framing bytes
    localparam logic [7:0] SYNC_BYTE = 8'h14;
    localparam logic [7:0] END_BYTE  = 8'h88;

    // ASCII characters used by commands and replies
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_H   = 8'h48;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] CH_P   = 8'h50;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_S   = 8'h53;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_U   = 8'h55;
    localparam logic [7:0] CH_Y   = 8'h59;

    // Item operation codes
    localparam logic OP_RX_BYTE     = 1'b0;
    localparam logic OP_TEMPERATURE = 1'b1;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Index of the final reply byte
    localparam logic [1:0] BYTE_LAST = 2'd2;

    // Input request
    typedef struct packed {
        logic        operation;
        logic [7:0]  rx_byte;
        logic [15:0] temperature_value;
    } item_t;

    // Output request
    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic [FRAME_W-1:0] frame_bits;
        logic               last;
    } result_t;

    // What the back end has to do for a classified command
    typedef enum logic [1:0] {
        ACT_SET   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_REPLY = 2'd3
    } action_t;

    // Queue entry: action plus the three reply bytes
    // (for a set, byte1 is the index and byte2 the value;
    //  for a read, byte2 is replaced by the table entry)
    typedef struct packed {
        action_t    action;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } entry_t;

endpackage

// File: design/uart_command_output_expander.sv
// UART command output expander. Throughput: one request a cycle for bytes and temperature
// updates without a reply, while the command queue is not full (item_stall low). The back
// sequencer handles a reply command as three bytes and a set or clear as table update,
// frame, three bytes, with a two-entry queue in between. Reset (rst_n, asynchronous,
// active low) zeroes the table, the temperature and the command bytes, and returns
// framing to idle.
module uart_command_output_expander #(
    parameter int NUM_OUTPUTS = uce_pkg::NUM_OUTPUTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  uce_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output uce_pkg::result_t result
);
    import uce_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   pop;
    logic   q_valid;
    entry_t q_entry;

    // Framing and classification
    uce_front #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Command queue
    uce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // Execution and result sequencing
    uce_back #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: design/uce_front.sv
// Front end: accepts requests, tracks command framing and classifies commands.
// Depends on uce_pkg; pushes classified commands into uce_queue.
module uce_front #(
    parameter int NUM_OUTPUTS = uce_pkg::NUM_OUTPUTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  uce_pkg::item_t  item,
    output logic            push,
    output uce_pkg::entry_t push_entry,
    input  logic            q_full
);
    import uce_pkg::*;

    localparam logic [7:0] NUM_BYTE = 8'(NUM_OUTPUTS);

    // Framing phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_CMD0 = 5'b00010,
        PH_CMD1 = 5'b00100,
        PH_CMD2 = 5'b01000,
        PH_END  = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  c0_reg, c0_next;
    logic [7:0]  c1_reg, c1_next;
    logic [7:0]  c2_reg, c2_next;
    logic [15:0] temp_reg, temp_next;

    logic   accept;
    logic   idx_ok;
    entry_t cmd_entry;
    entry_t err_entry;

    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    assign err_entry = '{action: ACT_REPLY, byte0: CH_E, byte1: CH_R, byte2: CH_R};

    // Classify the gathered command
    assign idx_ok = (c1_reg != 8'd0) && (c1_reg <= NUM_BYTE);

    always_comb
    begin
        priority if (c0_reg == CH_S && idx_ok)
        begin
            cmd_entry = '{action: ACT_SET, byte0: CH_S, byte1: c1_reg, byte2: c2_reg};
        end
        else if (c0_reg == CH_S && c1_reg == CH_A && c2_reg == CH_NUL)
        begin
            cmd_entry = '{action: ACT_CLEAR, byte0: CH_S, byte1: CH_A, byte2: CH_NUL};
        end
        else if (c0_reg == CH_R && idx_ok)
        begin
            cmd_entry = '{action: ACT_READ, byte0: CH_R, byte1: c1_reg, byte2: CH_NUL};
        end
        else if (c0_reg == CH_T && c1_reg == CH_M && c2_reg == CH_P)
        begin
            cmd_entry = '{action: ACT_REPLY, byte0: CH_NUL,
                          byte1: temp_reg[15:8], byte2: temp_reg[7:0]};
        end
        else
        begin
            cmd_entry = '{action: ACT_REPLY, byte0: CH_H, byte1: CH_U, byte2: CH_Y};
        end
    end

    // Framing and temperature update
    always_comb
    begin
        phase_next = phase_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        temp_next  = temp_reg;
        push       = 1'b0;
        push_entry = err_entry;
        if (accept)
        begin
            if (item.operation == OP_TEMPERATURE)
            begin
                temp_next = item.temperature_value;
            end
            else
            begin
                unique case (phase_reg)
                    PH_CMD0:
                    begin
                        c0_next    = item.rx_byte;
                        phase_next = PH_CMD1;
                    end
                    PH_CMD1:
                    begin
                        c1_next    = item.rx_byte;
                        phase_next = PH_CMD2;
                    end
                    PH_CMD2:
                    begin
                        c2_next    = item.rx_byte;
                        phase_next = PH_END;
                    end
                    PH_END:
                    begin
                        phase_next = PH_IDLE;
                        push       = 1'b1;
                        if (item.rx_byte == END_BYTE)
                        begin
                            push_entry = cmd_entry;
                        end
                    end
                    default:
                    begin
                        // idle: wait for sync, anything else is an error
                        if (item.rx_byte == SYNC_BYTE)
                        begin
                            phase_next = PH_CMD0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            c0_reg    <= 8'd0;
            c1_reg    <= 8'd0;
            c2_reg    <= 8'd0;
            temp_reg  <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            c0_reg    <= c0_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            temp_reg  <= temp_next;
        end
    end

    // A command goes to the queue only for an accepted received byte
    a_push_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && item.operation == OP_RX_BYTE))
        else $error("command pushed without an accepted byte");

    // Temperature updates leave the framing untouched
    a_temp_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_TEMPERATURE) |=> phase_reg == $past(phase_reg))
        else $error("temperature update changed framing phase");

    // The terminator slot always returns to idle and produces a command
    a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.operation == OP_RX_BYTE && phase_reg == PH_END)
        |-> push ##1 phase_reg == PH_IDLE)
        else $error("terminator did not close the frame");

endmodule

// File: design/uce_queue.sv
// Short first-word-fall-through queue of classified commands.
// Depends on uce_pkg; sits between uce_front and uce_back.
module uce_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uce_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output uce_pkg::entry_t q_entry
);
    import uce_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == DEPTH_CNT);
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

endmodule

// File: design/uce_back.sv
// Back end: owns the output table, executes commands and sequences results.
// Depends on uce_pkg; takes commands from uce_queue, drives the result port.
module uce_back #(
    parameter int NUM_OUTPUTS = uce_pkg::NUM_OUTPUTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  uce_pkg::entry_t  q_entry,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output uce_pkg::result_t result
);
    import uce_pkg::*;

    localparam int IDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    // Sequencer state, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FRAME = 3'b010,
        ST_BYTES = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    entry_t     cur_reg, cur_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] table_reg  [NUM_OUTPUTS];
    logic [7:0] table_next [NUM_OUTPUTS];
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic               load;
    logic [FRAME_W-1:0] frame;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [7:0]         byte_sel;

    // Output register may be refilled when empty or being taken
    assign load         = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Index of the entry named by a command (range checked in front end)
    assign wr_idx = IDX_W'(q_entry.byte1 - 8'd1);
    assign rd_idx = IDX_W'(cur_reg.byte1 - 8'd1);

    // Frame: one bit per entry that is nonzero
    for (genvar k = 0; k < FRAME_W; k++)
    begin : g_frame
        if (k < NUM_OUTPUTS && k < FRAME_ENTRIES)
        begin : g_bit
            assign frame[k] = |table_reg[k];
        end
        else
        begin : g_zero
            assign frame[k] = 1'b0;
        end
    end

    // Reply byte for the current position
    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    byte_sel = cur_reg.byte0;
            2'd1:    byte_sel = cur_reg.byte1;
            default: byte_sel = (cur_reg.action == ACT_READ) ? table_reg[rd_idx]
                                                             : cur_reg.byte2;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        table_next     = table_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cur_next = q_entry;
                    cnt_next = 2'd0;
                    unique case (q_entry.action)
                        ACT_SET:
                        begin
                            table_next[wr_idx] = q_entry.byte2;
                            state_next         = ST_FRAME;
                        end
                        ACT_CLEAR:
                        begin
                            for (int i = 0; i < NUM_OUTPUTS; i++)
                            begin
                                table_next[i] = 8'd0;
                            end
                            state_next = ST_FRAME;
                        end
                        default:
                        begin
                            state_next = ST_BYTES;
                        end
                    endcase
                end
            end
            ST_FRAME:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{kind: KIND_FRAME, tx_byte: 8'd0,
                                       frame_bits: frame, last: 1'b0};
                    state_next     = ST_BYTES;
                end
            end
            ST_BYTES:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{kind: KIND_BYTE, tx_byte: byte_sel,
                                       frame_bits: '0, last: (cnt_reg == BYTE_LAST)};
                    if (cnt_reg == BYTE_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = 2'(cnt_reg + 2'd1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_OUTPUTS; i++)
            begin
                table_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            table_reg     <= table_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // A waiting command is always taken from idle
    a_take_command: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid) |=> state_reg != ST_IDLE)
        else $error("command left in queue while idle");

    // A frame result is never the final result of a command
    a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_FRAME) |-> !result.last)
        else $error("frame marked as last");

    // After a clear every entry reads zero
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_entry.action == ACT_CLEAR) |=> frame == '0)
        else $error("table not cleared");

endmodule

// File: bench/uce_checker.sv
// Request and result monitor for the UART command output expander, with a predictor.
// Depends on uce_pkg; it is instantiated beside the block by the bench top.
`timescale 1ns / 1ps

module uce_checker #(
    parameter int NUM_OUTPUTS = uce_pkg::NUM_OUTPUTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  uce_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  uce_pkg::result_t result,
    output int               mismatches,
    output int               outstanding
);

    import uce_pkg::*;

    // Framing position: idle, three command bytes, then the terminator
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CMD0 = 3'd1;
    localparam logic [2:0] PH_TERM = 3'd4;

    // Mirror of the block's state
    logic [7:0]  out_entries [1:NUM_OUTPUTS];
    logic [2:0]  phase;
    logic [7:0]  cmd [0:2];
    logic [15:0] temp_word;

    // Replies predicted but not yet seen, oldest first
    result_t expected_replies [$];
    int      fault_tally;

    // Shift frame image: bit k-1 set when entry k is nonzero
    function automatic logic [FRAME_W-1:0] frame_image();
        logic [FRAME_W-1:0] img;
        img = '0;
        for (int k = 1; k <= FRAME_ENTRIES && k <= NUM_OUTPUTS; k++)
            if (out_entries[k] != 8'h00)
                img[k-1] = 1'b1;
        return img;
    endfunction

    task automatic queue_reply(input logic kind, input logic [7:0] txb,
                               input logic [FRAME_W-1:0] bits, input logic fin);
        result_t r;
        r.kind       = kind;
        r.tx_byte    = txb;
        r.frame_bits = bits;
        r.last       = fin;
        expected_replies.push_back(r);
    endtask

    task automatic queue_bytes(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2);
        queue_reply(KIND_BYTE, b0, '0, 1'b0);
        queue_reply(KIND_BYTE, b1, '0, 1'b0);
        queue_reply(KIND_BYTE, b2, '0, 1'b1);
    endtask

    // Decode a complete, correctly terminated command
    task automatic run_command();
        logic idx_ok;
        idx_ok = (cmd[1] != 8'h00) && (cmd[1] <= NUM_OUTPUTS);
        if (cmd[0] == CH_S && idx_ok)
        begin
            out_entries[cmd[1]] = cmd[2];
            queue_reply(KIND_FRAME, 8'h00, frame_image(), 1'b0);
            queue_bytes(CH_S, cmd[1], cmd[2]);
        end
        else if (cmd[0] == CH_S && cmd[1] == CH_A && cmd[2] == CH_NUL)
        begin
            for (int k = 1; k <= NUM_OUTPUTS; k++)
                out_entries[k] = 8'h00;
            queue_reply(KIND_FRAME, 8'h00, frame_image(), 1'b0);
            queue_bytes(CH_S, CH_A, CH_NUL);
        end
        else if (cmd[0] == CH_R && idx_ok)
            queue_bytes(CH_R, cmd[1], out_entries[cmd[1]]);
        else if (cmd[0] == CH_T && cmd[1] == CH_M && cmd[2] == CH_P)
            queue_bytes(CH_NUL, temp_word[15:8], temp_word[7:0]);
        else
            queue_bytes(CH_H, CH_U, CH_Y);
    endtask

    // Advance the mirror by one accepted request
    task automatic predict_request(input item_t req);
        if (req.operation == OP_TEMPERATURE)
            temp_word = req.temperature_value;
        else if (phase >= PH_CMD0 && phase < PH_TERM)
        begin
            cmd[phase - PH_CMD0] = req.rx_byte;
            phase = phase + 3'd1;
        end
        else if (phase == PH_TERM)
        begin
            phase = PH_IDLE;
            if (req.rx_byte == END_BYTE)
                run_command();
            else
                queue_bytes(CH_E, CH_R, CH_R);
        end
        else if (req.rx_byte == SYNC_BYTE)
            phase = PH_CMD0;
        else
        begin
            phase = PH_IDLE;
            queue_bytes(CH_E, CH_R, CH_R);
        end
    endtask

    // Sample both channels at the edge; compare results before predicting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NUM_OUTPUTS; k++)
                out_entries[k] = 8'h00;
            for (int k = 0; k < 3; k++)
                cmd[k] = 8'h00;
            phase       = PH_IDLE;
            temp_word   = 16'h0000;
            fault_tally = 0;
            expected_replies.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result: kind %0h tx_byte %h frame_bits %h last %0h",
                           result.kind, result.tx_byte, result.frame_bits, result.last);
                    fault_tally++;
                end
                else
                begin
                    result_t want;
                    want = expected_replies.pop_front();
                    if (result.kind !== want.kind)
                    begin
                        $error("kind: expected %0h, got %0h", want.kind, result.kind);
                        fault_tally++;
                    end
                    if (result.tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %h, got %h", want.tx_byte, result.tx_byte);
                        fault_tally++;
                    end
                    if (result.frame_bits !== want.frame_bits)
                    begin
                        $error("frame_bits: expected %h, got %h",
                               want.frame_bits, result.frame_bits);
                        fault_tally++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0h, got %0h", want.last, result.last);
                        fault_tally++;
                    end
                end
            end
            if (item_valid && !item_stall)
                predict_request(item);
            mismatches  <= fault_tally;
            outstanding <= expected_replies.size();
        end
    end

endmodule

// File: bench/uart_command_output_expander_tb.sv
// Bench top for the UART command output expander: clock, reset, request stimulus and verdict.
// Depends on uce_pkg, the block itself and uce_checker, which does all the checking.
`timescale 1ns / 1ps

module uart_command_output_expander_tb;

    import uce_pkg::*;

    localparam int          REQUEST_TARGET = 475;
    localparam int          DRAIN_SPACING  = 110;
    localparam int          SETTLE_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT    = 300000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int          mismatches;
    int          outstanding;
    int          issued;
    int          burst_left;
    int unsigned cycle_count = 0;

    uart_command_output_expander i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    uce_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure: a fresh mode for each randomly sized span
    initial
    begin
        int mode;
        int span;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(40, 300);
            for (int t = 0; t < span; t++)
            begin
                @(posedge clk);
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 9) < 3);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((t % 7) < 3);
                endcase
            end
        end
    end

    // Offer one request and hold it until taken; bursts end in a random gap
    task automatic send_request(input item_t req);
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (item_stall);
        issued++;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    task automatic send_byte(input logic [7:0] b);
        item_t req;
        req.operation         = OP_RX_BYTE;
        req.rx_byte           = b;
        req.temperature_value = 16'($urandom);
        send_request(req);
    endtask

    task automatic send_temp(input logic [15:0] value);
        item_t req;
        req.operation         = OP_TEMPERATURE;
        req.rx_byte           = 8'($urandom);
        req.temperature_value = value;
        send_request(req);
    endtask

    // Sync, three command bytes, terminator; optionally splice in temperature updates
    task automatic send_frame(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] term,
                              input bit splice);
        logic [7:0] seq [0:4];
        seq = '{SYNC_BYTE, c0, c1, c2, term};
        for (int k = 0; k < 5; k++)
        begin
            if (splice && $urandom_range(0, 5) == 0)
                send_temp(16'($urandom));
            send_byte(seq[k]);
        end
    endtask

    // Hold off until every predicted result has come back
    task automatic wait_drained();
        if (item_valid)
            item_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] term;
        int         next_drain;
        int         pick;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        issued     = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stray byte, full-scale temperature and its query, top index with top value,
        // index zero, bad terminator, clear
        send_byte(8'hFF);
        send_temp(16'hFFFF);
        send_frame(CH_T, CH_M, CH_P, END_BYTE, 1'b0);
        send_frame(CH_S, 8'(NUM_OUTPUTS_DEF), 8'hFF, END_BYTE, 1'b0);
        send_frame(CH_S, 8'h00, 8'h5A, END_BYTE, 1'b0);
        send_frame(CH_R, 8'h01, 8'h00, 8'h00, 1'b0);
        send_frame(CH_S, CH_A, CH_NUL, END_BYTE, 1'b0);
        wait_drained();

        // Random: mostly well-formed commands, with broken frames and noise
        next_drain = issued + DRAIN_SPACING;
        while (issued < REQUEST_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                term = END_BYTE;
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        c0 = CH_S;
                        c1 = 8'($urandom_range(1, NUM_OUTPUTS_DEF));
                        c2 = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
                    end
                    3:
                    begin
                        c0 = CH_S;
                        c1 = CH_A;
                        c2 = CH_NUL;
                    end
                    4, 5:
                    begin
                        c0 = CH_R;
                        c1 = 8'($urandom_range(1, NUM_OUTPUTS_DEF));
                        c2 = 8'($urandom);
                    end
                    6:
                    begin
                        c0 = CH_T;
                        c1 = CH_M;
                        c2 = CH_P;
                    end
                    default:
                    begin
                        // Near misses: bad index, clear with nonzero value, odd letters
                        case ($urandom_range(0, 4))
                            0: c0 = CH_S;
                            1: c0 = CH_R;
                            2: c0 = CH_T;
                            default: c0 = 8'($urandom);
                        endcase
                        case ($urandom_range(0, 4))
                            0: c1 = 8'h00;
                            1: c1 = 8'(NUM_OUTPUTS_DEF + 1);
                            2: c1 = CH_A;
                            3: c1 = CH_M;
                            default: c1 = 8'($urandom);
                        endcase
                        c2 = ($urandom_range(0, 1) == 0) ? CH_P : 8'($urandom);
                    end
                endcase
                send_frame(c0, c1, c2, term, 1'b1);
            end
            else if (pick < 84)
            begin
                term = 8'($urandom);
                if (term == END_BYTE)
                    term = ~term;
                send_frame(CH_S, CH_A, CH_NUL, term, 1'b1);
            end
            else if (pick < 93)
                send_byte(8'($urandom));
            else
                send_temp(16'($urandom));

            if (issued >= next_drain)
            begin
                wait_drained();
                next_drain = issued + DRAIN_SPACING;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
